/* hw/rtl/bsfc_pkg.sv */
// Package for the balance state feedback controller.
// Holds the sequencer step type, the control and status structs, fixed-point widths,
// scaling constants, register indexes and rounding/saturation helpers.
package bsfc_pkg;

   localparam int ACCEL_W = 17;
   localparam int GYRO_W  = 16;
   localparam int WHEEL_W = 18;
   localparam int DRIVE_W = 18;
   localparam int STATE_W = 32;

   localparam int MUL_A_W = 45;
   localparam int MUL_B_W = 21;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int TILT_W  = 25;
   localparam int RATE_W  = 23;
   localparam int COMP_W  = 34;
   localparam int U_W     = 44;
   localparam int DRV_SUM_W = 52;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 18;

   localparam int DEG2RAD_Q24    = 292818;
   localparam int DEG2RAD_DT_Q32 = 749613;
   localparam int MILLI_Q20      = 1049;
   localparam int TILT_BIAS_Q16  = 473;
   localparam int BLEND_GYRO_Q16 = 62259;
   localparam int BLEND_TILT_Q16 = 3277;

   localparam logic [CSR_INDEX_W-1:0] REG_TILT_GAIN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_GAIN     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_INTEGRAL_GAIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WHEEL_GAIN    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_WHEEL_LIMIT   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STALL_OFFSET  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RIGHT_TRIM    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_DEAD_BAND     = 3'd7;

   localparam logic [17:0] TILT_GAIN_RST     = 18'd102400;
   localparam logic [15:0] RATE_GAIN_RST     = 16'd205;
   localparam logic [15:0] INTEGRAL_GAIN_RST = 16'd384;
   localparam logic [15:0] WHEEL_GAIN_RST    = 16'd2560;
   localparam logic [16:0] WHEEL_LIMIT_RST   = 17'd8192;
   localparam logic [15:0] STALL_OFFSET_RST  = 16'd4506;
   localparam logic [15:0] RIGHT_TRIM_RST    = 16'd34406;
   localparam logic [15:0] DEAD_BAND_RST     = 16'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ACCEL,
      S_TSUM,
      S_RATE,
      S_GDT,
      S_GUPD,
      S_BLG,
      S_COMP,
      S_RG,
      S_IG,
      S_WG,
      S_UACC,
      S_URND,
      S_TRIM,
      S_DRV
   } step_type;

   typedef struct packed {
      step_type step;
      logic     load_rsp;
   } ctrl_type;

   typedef struct packed {
      logic start;
      logic quiet;
      logic rsp_free;
   } status_type;

   function automatic logic signed [PROD_W-1:0] round_shr(
      input logic signed [PROD_W-1:0] v,
      input int unsigned              sh
   );
      logic signed [PROD_W-1:0] half;
      half = PROD_W'(1) <<< (sh - 1);
      return (v + half) >>> sh;
   endfunction

   function automatic logic signed [STATE_W-1:0] sat_state(
      input logic signed [STATE_W:0] v
   );
      logic signed [STATE_W:0] hi;
      logic signed [STATE_W:0] lo;
      hi = {2'b00, {(STATE_W-1){1'b1}}};
      lo = {2'b11, {(STATE_W-1){1'b0}}};
      if (v > hi) begin
         return hi[STATE_W-1:0];
      end else if (v < lo) begin
         return lo[STATE_W-1:0];
      end
      return v[STATE_W-1:0];
   endfunction

   function automatic logic signed [DRIVE_W-1:0] sat_drive(
      input logic signed [DRV_SUM_W-1:0] v
   );
      logic signed [DRV_SUM_W-1:0] hi;
      logic signed [DRV_SUM_W-1:0] lo;
      hi = {{(DRV_SUM_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
      lo = {{(DRV_SUM_W-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};
      if (v > hi) begin
         return hi[DRIVE_W-1:0];
      end else if (v < lo) begin
         return lo[DRIVE_W-1:0];
      end
      return v[DRIVE_W-1:0];
   endfunction

endpackage

/* hw/rtl/bsfc_mul.sv */
// Shared signed multiplier with a registered product.
// Uses widths from bsfc_pkg.
module bsfc_mul (
   input  logic                                   clock,
   input  logic signed [bsfc_pkg::MUL_A_W-1:0]    a,
   input  logic signed [bsfc_pkg::MUL_B_W-1:0]    b,
   output logic signed [bsfc_pkg::PROD_W-1:0]     prod_ff
);

   logic signed [bsfc_pkg::PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = bsfc_pkg::PROD_W'(a) * bsfc_pkg::PROD_W'(b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* hw/rtl/bsfc_seq.sv */
// Step sequencer driving the shared multiplier datapath.
// Uses step_type, ctrl_type and status_type from bsfc_pkg.
module bsfc_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  bsfc_pkg::status_type status,
   output bsfc_pkg::ctrl_type   ctrl
);

   bsfc_pkg::step_type state_ff;
   bsfc_pkg::step_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsfc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      ctrl.step     = state_ff;
      ctrl.load_rsp = 1'b0;
      unique case (state_ff)
         bsfc_pkg::S_IDLE: begin
            if (status.start) begin
               state_in = bsfc_pkg::S_ACCEL;
            end
         end
         bsfc_pkg::S_ACCEL: state_in = bsfc_pkg::S_TSUM;
         bsfc_pkg::S_TSUM:  state_in = bsfc_pkg::S_RATE;
         bsfc_pkg::S_RATE:  state_in = bsfc_pkg::S_GDT;
         bsfc_pkg::S_GDT:   state_in = bsfc_pkg::S_GUPD;
         bsfc_pkg::S_GUPD:  state_in = bsfc_pkg::S_BLG;
         bsfc_pkg::S_BLG:   state_in = bsfc_pkg::S_COMP;
         bsfc_pkg::S_COMP:  state_in = bsfc_pkg::S_RG;
         bsfc_pkg::S_RG:    state_in = bsfc_pkg::S_IG;
         bsfc_pkg::S_IG:    state_in = bsfc_pkg::S_WG;
         bsfc_pkg::S_WG:    state_in = bsfc_pkg::S_UACC;
         bsfc_pkg::S_UACC:  state_in = bsfc_pkg::S_URND;
         bsfc_pkg::S_URND:  state_in = bsfc_pkg::S_TRIM;
         bsfc_pkg::S_TRIM: begin
            if (status.quiet) begin
               state_in = bsfc_pkg::S_IDLE;
            end else begin
               state_in = bsfc_pkg::S_DRV;
            end
         end
         bsfc_pkg::S_DRV: begin
            if (status.rsp_free) begin
               ctrl.load_rsp = 1'b1;
               state_in      = bsfc_pkg::S_IDLE;
            end
         end
         default: state_in = bsfc_pkg::S_IDLE;
      endcase
   end

endmodule

/* hw/rtl/balance_state_feedback_control.sv */
// Balance controller top level: stream ports, configuration registers,
// filter and feedback datapath. Uses bsfc_pkg, bsfc_mul and bsfc_seq.
//
// Each item is one sensor sample. The block takes it and works through a
// fixed sequence of steps on one shared 45x21 multiplier. It takes the
// next item only once it is done with the last: after a drive result is
// loaded, or after a command that falls inside the deadband and gives no
// result. A finished result sits in an output register. If that register
// has not been taken when the next result is due, the block holds in its
// last step until the register frees. Configuration writes are taken in
// any cycle.
module balance_state_feedback_control (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // accel_roll[16:0], gyro_rate[32:17], wheel_angle[50:33]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // right_drive[17:0], left_drive[35:18]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [bsfc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bsfc_pkg::CSR_DATA_W-1:0]  csr_data
);

   bsfc_pkg::ctrl_type   ctrl;
   bsfc_pkg::status_type status;

   logic [17:0] tilt_gain_ff;
   logic [15:0] rate_gain_ff;
   logic [15:0] integral_gain_ff;
   logic [15:0] wheel_gain_ff;
   logic [16:0] wheel_limit_ff;
   logic [15:0] stall_offset_ff;
   logic [15:0] right_trim_ff;
   logic [15:0] dead_band_ff;

   logic signed [bsfc_pkg::ACCEL_W-1:0] accel_ff;
   logic signed [bsfc_pkg::GYRO_W-1:0]  gyro_ff;
   logic signed [bsfc_pkg::WHEEL_W-1:0] wheel_ff;
   logic signed [bsfc_pkg::WHEEL_W-1:0] wheel_in;

   logic signed [bsfc_pkg::STATE_W-1:0] tilt_sum_ff,   tilt_sum_in;
   logic signed [bsfc_pkg::STATE_W-1:0] gyro_angle_ff, gyro_angle_in;
   logic signed [bsfc_pkg::TILT_W-1:0]  tilt_ff,       tilt_in;
   logic signed [bsfc_pkg::RATE_W-1:0]  rate_ff,       rate_in;
   logic signed [bsfc_pkg::COMP_W-1:0]  comp_ff,       comp_in;
   logic signed [bsfc_pkg::U_W-1:0]     u_ff,          u_in;
   logic signed [bsfc_pkg::PROD_W-1:0]  acc_ff,        acc_in;

   logic signed [bsfc_pkg::MUL_A_W-1:0] mul_a;
   logic signed [bsfc_pkg::MUL_B_W-1:0] mul_b;
   logic signed [bsfc_pkg::PROD_W-1:0]  prod_ff;
   logic signed [bsfc_pkg::PROD_W-1:0]  rnd;

   logic signed [bsfc_pkg::WHEEL_W:0]   lim_pos;
   logic signed [bsfc_pkg::WHEEL_W:0]   lim_neg;
   logic signed [bsfc_pkg::WHEEL_W:0]   wheel_ext;
   logic signed [bsfc_pkg::U_W-1:0]     db_pos;
   logic signed [bsfc_pkg::U_W-1:0]     db_neg;
   logic                                u_pos;

   logic signed [bsfc_pkg::DRV_SUM_W-1:0] stall_s;
   logic signed [bsfc_pkg::DRV_SUM_W-1:0] right_sum;
   logic signed [bsfc_pkg::DRV_SUM_W-1:0] left_sum;
   logic signed [bsfc_pkg::DRIVE_W-1:0]   right_ff, right_in;
   logic signed [bsfc_pkg::DRIVE_W-1:0]   left_ff,  left_in;
   logic                                  rsp_valid_ff, rsp_valid_in;

   bsfc_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   bsfc_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod_ff)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (ctrl.step == bsfc_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, left_ff, right_ff};

   assign db_pos = bsfc_pkg::U_W'($signed({1'b0, dead_band_ff}));
   assign db_neg = -db_pos;

   assign status.start    = req_tvalid && req_tready;
   assign status.quiet    = !(u_ff > db_pos) && !(u_ff < db_neg);
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_gain_ff     <= bsfc_pkg::TILT_GAIN_RST;
         rate_gain_ff     <= bsfc_pkg::RATE_GAIN_RST;
         integral_gain_ff <= bsfc_pkg::INTEGRAL_GAIN_RST;
         wheel_gain_ff    <= bsfc_pkg::WHEEL_GAIN_RST;
         wheel_limit_ff   <= bsfc_pkg::WHEEL_LIMIT_RST;
         stall_offset_ff  <= bsfc_pkg::STALL_OFFSET_RST;
         right_trim_ff    <= bsfc_pkg::RIGHT_TRIM_RST;
         dead_band_ff     <= bsfc_pkg::DEAD_BAND_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bsfc_pkg::REG_TILT_GAIN:     tilt_gain_ff     <= csr_data;
            bsfc_pkg::REG_RATE_GAIN:     rate_gain_ff     <= csr_data[15:0];
            bsfc_pkg::REG_INTEGRAL_GAIN: integral_gain_ff <= csr_data[15:0];
            bsfc_pkg::REG_WHEEL_GAIN:    wheel_gain_ff    <= csr_data[15:0];
            bsfc_pkg::REG_WHEEL_LIMIT:   wheel_limit_ff   <= csr_data[16:0];
            bsfc_pkg::REG_STALL_OFFSET:  stall_offset_ff  <= csr_data[15:0];
            bsfc_pkg::REG_RIGHT_TRIM:    right_trim_ff    <= csr_data[15:0];
            bsfc_pkg::REG_DEAD_BAND:     dead_band_ff     <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (status.start) begin
         accel_ff <= req_tdata[16:0];
         gyro_ff  <= req_tdata[32:17];
         wheel_ff <= req_tdata[50:33];
      end
   end

   // clamp wheel angle to the symmetric limit
   assign lim_pos   = $signed({2'b00, wheel_limit_ff});
   assign lim_neg   = -lim_pos;
   assign wheel_ext = (bsfc_pkg::WHEEL_W + 1)'(wheel_ff);

   always_comb begin
      if (wheel_ext > lim_pos) begin
         wheel_in = lim_pos[bsfc_pkg::WHEEL_W-1:0];
      end else if (wheel_ext < lim_neg) begin
         wheel_in = lim_neg[bsfc_pkg::WHEEL_W-1:0];
      end else begin
         wheel_in = wheel_ff;
      end
   end

   always_comb begin
      mul_a         = '0;
      mul_b         = '0;
      rnd           = '0;
      tilt_sum_in   = tilt_sum_ff;
      gyro_angle_in = gyro_angle_ff;
      tilt_in       = tilt_ff;
      rate_in       = rate_ff;
      comp_in       = comp_ff;
      u_in          = u_ff;
      acc_in        = acc_ff;
      unique case (ctrl.step)
         bsfc_pkg::S_ACCEL: begin
            mul_a = bsfc_pkg::MUL_A_W'(accel_ff);
            mul_b = bsfc_pkg::MUL_B_W'(bsfc_pkg::DEG2RAD_Q24);
         end
         bsfc_pkg::S_TSUM: begin
            mul_a   = bsfc_pkg::MUL_A_W'(tilt_sum_ff);
            mul_b   = bsfc_pkg::MUL_B_W'(bsfc_pkg::MILLI_Q20);
            rnd     = bsfc_pkg::round_shr(prod_ff, 16);
            tilt_in = rnd[bsfc_pkg::TILT_W-1:0]
                    - bsfc_pkg::TILT_W'(bsfc_pkg::TILT_BIAS_Q16);
         end
         bsfc_pkg::S_RATE: begin
            mul_a   = bsfc_pkg::MUL_A_W'(gyro_ff);
            mul_b   = bsfc_pkg::MUL_B_W'(bsfc_pkg::DEG2RAD_Q24);
            rnd     = bsfc_pkg::round_shr(prod_ff, 20);
            tilt_in = tilt_ff - rnd[bsfc_pkg::TILT_W-1:0];
         end
         bsfc_pkg::S_GDT: begin
            mul_a       = bsfc_pkg::MUL_A_W'(gyro_ff);
            mul_b       = bsfc_pkg::MUL_B_W'(bsfc_pkg::DEG2RAD_DT_Q32);
            rnd         = bsfc_pkg::round_shr(prod_ff, 12);
            rate_in     = rnd[bsfc_pkg::RATE_W-1:0];
            tilt_sum_in = bsfc_pkg::sat_state((bsfc_pkg::STATE_W + 1)'(tilt_sum_ff)
                        + (bsfc_pkg::STATE_W + 1)'(tilt_ff));
         end
         bsfc_pkg::S_GUPD: begin
            mul_a         = bsfc_pkg::MUL_A_W'(tilt_ff);
            mul_b         = bsfc_pkg::MUL_B_W'(bsfc_pkg::BLEND_TILT_Q16);
            rnd           = bsfc_pkg::round_shr(prod_ff, 20);
            gyro_angle_in = bsfc_pkg::sat_state((bsfc_pkg::STATE_W + 1)'(gyro_angle_ff)
                          + rnd[bsfc_pkg::STATE_W:0]);
         end
         bsfc_pkg::S_BLG: begin
            mul_a  = bsfc_pkg::MUL_A_W'(gyro_angle_ff);
            mul_b  = bsfc_pkg::MUL_B_W'(bsfc_pkg::BLEND_GYRO_Q16);
            acc_in = prod_ff;
         end
         bsfc_pkg::S_COMP: begin
            mul_a   = bsfc_pkg::MUL_A_W'(rate_ff);
            mul_b   = bsfc_pkg::MUL_B_W'($signed({1'b0, rate_gain_ff}));
            rnd     = bsfc_pkg::round_shr(acc_ff + prod_ff, 16);
            comp_in = rnd[bsfc_pkg::COMP_W-1:0];
         end
         bsfc_pkg::S_RG: begin
            mul_a  = bsfc_pkg::MUL_A_W'(comp_ff);
            mul_b  = bsfc_pkg::MUL_B_W'($signed({1'b0, tilt_gain_ff}));
            acc_in = prod_ff;
         end
         bsfc_pkg::S_IG: begin
            mul_a  = bsfc_pkg::MUL_A_W'(tilt_sum_ff);
            mul_b  = bsfc_pkg::MUL_B_W'($signed({1'b0, integral_gain_ff}));
            acc_in = acc_ff + prod_ff;
         end
         bsfc_pkg::S_WG: begin
            mul_a  = bsfc_pkg::MUL_A_W'(wheel_in);
            mul_b  = bsfc_pkg::MUL_B_W'($signed({1'b0, wheel_gain_ff}));
            acc_in = acc_ff + prod_ff;
         end
         bsfc_pkg::S_UACC: begin
            acc_in = acc_ff + (prod_ff <<< 4);
         end
         bsfc_pkg::S_URND: begin
            rnd  = bsfc_pkg::round_shr(acc_ff, 12);
            u_in = rnd[bsfc_pkg::U_W-1:0];
         end
         bsfc_pkg::S_TRIM: begin
            mul_a = bsfc_pkg::MUL_A_W'(u_ff);
            mul_b = bsfc_pkg::MUL_B_W'($signed({1'b0, right_trim_ff}));
         end
         bsfc_pkg::S_DRV: begin
            // hold the trim product while the output register is busy
            mul_a = bsfc_pkg::MUL_A_W'(u_ff);
            mul_b = bsfc_pkg::MUL_B_W'($signed({1'b0, right_trim_ff}));
            rnd   = bsfc_pkg::round_shr(prod_ff, 15);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_sum_ff   <= '0;
         gyro_angle_ff <= '0;
      end else begin
         tilt_sum_ff   <= tilt_sum_in;
         gyro_angle_ff <= gyro_angle_in;
      end
   end

   always_ff @(posedge clock) begin
      tilt_ff <= tilt_in;
      rate_ff <= rate_in;
      comp_ff <= comp_in;
      u_ff    <= u_in;
      acc_ff  <= acc_in;
   end

   // add stall offset away from zero, then saturate both drives
   assign u_pos   = u_ff > db_pos;
   assign stall_s = $signed({{(bsfc_pkg::DRV_SUM_W-16){1'b0}}, stall_offset_ff});

   always_comb begin
      if (u_pos) begin
         right_sum = rnd[bsfc_pkg::DRV_SUM_W-1:0] + stall_s;
         left_sum  = bsfc_pkg::DRV_SUM_W'(u_ff) + stall_s;
      end else begin
         right_sum = rnd[bsfc_pkg::DRV_SUM_W-1:0] - stall_s;
         left_sum  = bsfc_pkg::DRV_SUM_W'(u_ff) - stall_s;
      end
      right_in = bsfc_pkg::sat_drive(right_sum);
      left_in  = bsfc_pkg::sat_drive(left_sum);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (ctrl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_rsp) begin
         right_ff <= right_in;
         left_ff  <= left_in;
      end
   end

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while an item is in progress");

   a_rsp_from_drive: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.step == bsfc_pkg::S_DRV))
      else $error("result raised outside the drive step");

   a_rsp_outside_band: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ((u_ff > db_pos) || (u_ff < db_neg)))
      else $error("result emitted inside the deadband");
`endif

endmodule
